// ===== sv/gts_pkg.sv =====
`default_nettype none
package gts_pkg;

  localparam int MAX_ITEMS  = 32;
  localparam int MAX_GROUPS = 64;
  localparam int IDX_W      = $clog2(MAX_ITEMS);
  localparam int GID_W      = $clog2(MAX_GROUPS);
  localparam int NUM_W      = IDX_W + 1;
  localparam int GNUM_W     = GID_W + 1;

  localparam logic [GID_W-1:0] NO_GROUP    = '1;
  localparam logic [NUM_W-1:0] GIVEN_LIMIT = NUM_W'(MAX_ITEMS);

  typedef enum logic [1:0] {
    OP_SET_GROUP = 2'd0,
    OP_ADD_EDGE  = 2'd1,
    OP_RUN       = 2'd2,
    OP_NONE      = 2'd3
  } gts_op_t;

  localparam logic CFG_ITEM_COUNT  = 1'b0;
  localparam logic CFG_GROUP_COUNT = 1'b1;

  typedef struct packed {
    logic load;
    logic run_start;
    logic asgn;
    logic ginit;
    logic gtake;
    logic gscan;
    logic iinit;
    logic ipop;
    logic iscan;
    logic eread;
    logic etake;
    logic emit_phase;
    logic escan;
    logic enext;
    logic fail;
    logic clear;
    logic cnt_clr;
  } gts_cmd_t;

  typedef struct packed {
    logic cnt_at_n;
    logic cnt_at_total;
    logic gq_empty;
    logic gq_done;
    logic iq_empty;
    logic iq_done;
    logic eg_done;
    logic out_free;
    logic emit_hit;
  } gts_sts_t;

endpackage
`default_nettype wire

// ===== sv/gts_ram.sv =====
`default_nettype none
module gts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== sv/gts_ctrl.sv =====
`default_nettype none
module gts_ctrl import gts_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_tvalid,
  input  wire logic [1:0] in_op,
  output logic          in_tready,
  input  wire gts_sts_t sts,
  output gts_cmd_t      cmd
);

  typedef enum logic [13:0] {
    ST_IDLE   = 14'b00000000000001,
    ST_ASSIGN = 14'b00000000000010,
    ST_GINIT  = 14'b00000000000100,
    ST_GPOP   = 14'b00000000001000,
    ST_GTAKE  = 14'b00000000010000,
    ST_GSCAN  = 14'b00000000100000,
    ST_IINIT  = 14'b00000001000000,
    ST_IPOP   = 14'b00000010000000,
    ST_ISCAN  = 14'b00000100000000,
    ST_EREAD  = 14'b00001000000000,
    ST_ETAKE  = 14'b00010000000000,
    ST_ESCAN  = 14'b00100000000000,
    ST_FAIL   = 14'b01000000000000,
    ST_CLEAR  = 14'b10000000000000
  } gts_state_t;

  gts_state_t state_r, state_nxt;
  logic       accept;

  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_op == OP_RUN) begin
            cmd.run_start = 1'b1;
            state_nxt     = ST_ASSIGN;
          end else begin
            cmd.load = 1'b1;
          end
        end
      end
      ST_ASSIGN: begin
        if (sts.cnt_at_n) begin
          cmd.cnt_clr = 1'b1;
          state_nxt   = ST_GINIT;
        end else begin
          cmd.asgn = 1'b1;
        end
      end
      ST_GINIT: begin
        if (sts.cnt_at_total) begin
          cmd.cnt_clr = 1'b1;
          state_nxt   = ST_GPOP;
        end else begin
          cmd.ginit = 1'b1;
        end
      end
      ST_GPOP: begin
        if (sts.gq_empty) begin
          state_nxt = sts.gq_done ? ST_IINIT : ST_FAIL;
        end else begin
          state_nxt = ST_GTAKE;
        end
      end
      ST_GTAKE: begin
        cmd.gtake = 1'b1;
        state_nxt = ST_GSCAN;
      end
      ST_GSCAN: begin
        if (sts.cnt_at_total) begin
          cmd.cnt_clr = 1'b1;
          state_nxt   = ST_GPOP;
        end else begin
          cmd.gscan = 1'b1;
        end
      end
      ST_IINIT: begin
        if (sts.cnt_at_n) begin
          cmd.cnt_clr = 1'b1;
          state_nxt   = ST_IPOP;
        end else begin
          cmd.iinit = 1'b1;
        end
      end
      ST_IPOP: begin
        if (sts.iq_empty) begin
          state_nxt = sts.iq_done ? ST_EREAD : ST_FAIL;
        end else begin
          cmd.ipop  = 1'b1;
          state_nxt = ST_ISCAN;
        end
      end
      ST_ISCAN: begin
        if (sts.cnt_at_n) begin
          cmd.cnt_clr = 1'b1;
          state_nxt   = ST_IPOP;
        end else begin
          cmd.iscan = 1'b1;
        end
      end
      ST_EREAD: begin
        cmd.eread = 1'b1;
        state_nxt = sts.eg_done ? ST_CLEAR : ST_ETAKE;
      end
      ST_ETAKE: begin
        cmd.etake = 1'b1;
        state_nxt = ST_ESCAN;
      end
      ST_ESCAN: begin
        cmd.emit_phase = 1'b1;
        if (sts.cnt_at_n) begin
          cmd.cnt_clr = 1'b1;
          cmd.enext   = 1'b1;
          state_nxt   = ST_EREAD;
        end else if (!sts.emit_hit || sts.out_free) begin
          cmd.escan = 1'b1;
        end
      end
      ST_FAIL: begin
        if (sts.out_free) begin
          cmd.fail  = 1'b1;
          state_nxt = ST_CLEAR;
        end
      end
      ST_CLEAR: begin
        cmd.clear = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== sv/gts_dp.sv =====
`default_nettype none
module gts_dp import gts_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire gts_cmd_t         cmd,
  output gts_sts_t              sts,
  input  wire logic             cfg_we,
  input  wire logic             cfg_addr,
  input  wire logic [NUM_W-1:0] cfg_wdata,
  input  wire logic [1:0]       in_op,
  input  wire logic [IDX_W-1:0] in_idx,
  input  wire logic [GID_W-1:0] in_grp,
  input  wire logic [IDX_W-1:0] in_bef,
  input  wire logic             out_tready,
  output logic                  out_tvalid,
  output logic [IDX_W-1:0]      out_item,
  output logic                  out_failed,
  output logic                  out_last
);

  logic [NUM_W-1:0]     item_count_r, group_count_r;
  logic [GID_W-1:0]     grp_r [MAX_ITEMS];
  logic [MAX_ITEMS-1:0] succ_r [MAX_ITEMS];
  logic [IDX_W-1:0]     iseq_r [MAX_ITEMS];
  logic [GNUM_W-1:0]    fresh_r, cnt_r, ghead_r, gtail_r, eg_r;
  logic [NUM_W-1:0]     ihead_r, itail_r, ecnt_r;
  logic [MAX_ITEMS-1:0] gdone_r, idone_r, gcur_r, vrow_r;
  logic [GID_W-1:0]     grp_sel_r;
  logic                 out_valid_r;

  logic [NUM_W-1:0]     n, base;
  logic [MAX_ITEMS-1:0] nmask, memb_h, pred, col, memb_rd;
  logic [GID_W-1:0]     hsel, ram_rdata, asg_g;
  logic [IDX_W-1:0]     iaddr, iseq_rd;
  logic                 ram_we, ready_k, iq_hit, emit, out_free;

  assign n    = (item_count_r  > GIVEN_LIMIT) ? GIVEN_LIMIT : item_count_r;
  assign base = (group_count_r > GIVEN_LIMIT) ? GIVEN_LIMIT : group_count_r;
  assign hsel = cnt_r[GID_W-1:0];

  always_comb begin
    for (int d = 0; d < MAX_ITEMS; d++) begin
      nmask[d]   = (NUM_W'(d) < n);
      memb_h[d]  = nmask[d] && (grp_r[d] == hsel);
      memb_rd[d] = nmask[d] && (grp_r[d] == ram_rdata);
      col[d]     = succ_r[d][cnt_r[IDX_W-1:0]];
    end
    for (int d = 0; d < MAX_ITEMS; d++) begin
      pred[d] = nmask[d] && (grp_r[d] != hsel) && (|(succ_r[d] & memb_h));
    end
  end

  assign ready_k  = ~|(col & nmask & ~idone_r);
  assign iq_hit   = (cmd.iinit && ready_k) || (cmd.iscan && vrow_r[cnt_r[IDX_W-1:0]] && ready_k);
  assign ram_we   = (cmd.ginit && ~|pred) ||
                    (cmd.gscan && (|(pred & gcur_r)) && ~|(pred & ~gdone_r));
  assign iaddr    = cmd.emit_phase ? cnt_r[IDX_W-1:0] : ihead_r[IDX_W-1:0];
  assign iseq_rd  = iseq_r[iaddr];
  assign out_free = !out_valid_r || out_tready;
  assign emit     = cmd.escan && sts.emit_hit;
  assign asg_g    = grp_r[cnt_r[IDX_W-1:0]];

  gts_ram #(
    .WIDTH (GID_W),
    .DEPTH (MAX_GROUPS)
  ) u_gseq (
    .clk   (clk),
    .we    (ram_we),
    .waddr (gtail_r[GID_W-1:0]),
    .wdata (hsel),
    .raddr (cmd.eread ? eg_r[GID_W-1:0] : ghead_r[GID_W-1:0]),
    .rdata (ram_rdata)
  );

  always_comb begin
    sts.cnt_at_n     = (cnt_r == {1'b0, n});
    sts.cnt_at_total = (cnt_r == fresh_r);
    sts.gq_empty     = (ghead_r == gtail_r);
    sts.gq_done      = (ghead_r == fresh_r);
    sts.iq_empty     = (ihead_r == itail_r);
    sts.iq_done      = (ihead_r == n);
    sts.eg_done      = (eg_r == fresh_r);
    sts.out_free     = out_free;
    sts.emit_hit     = (grp_r[iseq_rd] == grp_sel_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_count_r  <= NUM_W'(1);
      group_count_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_ITEM_COUNT:  item_count_r  <= cfg_wdata;
        CFG_GROUP_COUNT: group_count_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      for (int d = 0; d < MAX_ITEMS; d++) begin
        grp_r[d]  <= NO_GROUP;
        succ_r[d] <= '0;
      end
    end else begin
      if (cmd.load) begin
        unique case (in_op)
          OP_SET_GROUP: grp_r[in_idx] <= in_grp;
          OP_ADD_EDGE:  succ_r[in_bef][in_idx] <= 1'b1;
          default: ;
        endcase
      end
      if (cmd.asgn) begin
        if (asg_g < base) begin
          grp_r[cnt_r[IDX_W-1:0]] <= asg_g;
        end else begin
          grp_r[cnt_r[IDX_W-1:0]] <= fresh_r[GID_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fresh_r <= '0;
      cnt_r   <= '0;
      ghead_r <= '0;
      gtail_r <= '0;
      ihead_r <= '0;
      itail_r <= '0;
      eg_r    <= '0;
      ecnt_r  <= '0;
      gdone_r <= '0;
      idone_r <= '0;
    end else if (cmd.run_start) begin
      fresh_r <= {1'b0, base};
      cnt_r   <= '0;
      ghead_r <= '0;
      gtail_r <= '0;
      ihead_r <= '0;
      itail_r <= '0;
      eg_r    <= '0;
      ecnt_r  <= '0;
      gdone_r <= '0;
      idone_r <= '0;
    end else begin
      if (cmd.cnt_clr) begin
        cnt_r <= '0;
      end else if (cmd.asgn || cmd.ginit || cmd.gscan || cmd.iinit || cmd.iscan ||
                   cmd.escan) begin
        cnt_r <= cnt_r + 1'b1;
      end
      if (cmd.asgn && !(asg_g < base)) begin
        fresh_r <= fresh_r + 1'b1;
      end
      if (ram_we) begin
        gtail_r <= gtail_r + 1'b1;
      end
      if (cmd.gtake) begin
        ghead_r <= ghead_r + 1'b1;
        gdone_r <= gdone_r | memb_rd;
      end
      if (iq_hit) begin
        itail_r <= itail_r + 1'b1;
      end
      if (cmd.ipop) begin
        ihead_r <= ihead_r + 1'b1;
        idone_r <= idone_r | (MAX_ITEMS'(1) << iseq_rd);
      end
      if (cmd.enext) begin
        eg_r <= eg_r + 1'b1;
      end
      if (emit) begin
        ecnt_r <= ecnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (iq_hit) begin
      iseq_r[itail_r[IDX_W-1:0]] <= cnt_r[IDX_W-1:0];
    end
    if (cmd.gtake) begin
      gcur_r <= memb_rd;
    end
    if (cmd.ipop) begin
      vrow_r <= succ_r[iseq_rd];
    end
    if (cmd.etake) begin
      grp_sel_r <= ram_rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit || cmd.fail) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_item   <= iseq_rd;
      out_failed <= 1'b0;
      out_last   <= (ecnt_r == n - 1'b1);
    end else if (cmd.fail) begin
      out_item   <= '0;
      out_failed <= 1'b1;
      out_last   <= 1'b1;
    end
  end

  assign out_tvalid = out_valid_r;

endmodule
`default_nettype wire

// ===== sv/grouped_topological_sort_core.sv =====
// Grouped topological sort core.
// Input stream: each beat is one command (in_tuser): set an item's group,
// add a dependency edge, run, or do nothing (OP_NONE). Set/edge beats are taken one per cycle.
// A run beat assigns fresh group ids, orders the groups and then the items
// with a ready-queue walk over the dependency bit matrix, and emits one
// output beat per item, group by group; out_tlast marks the final beat.
// A cycle among groups or items gives a single beat with out_tuser high.
// The group and item scan loops make one vertex test per cycle, and the group
// order lives in a 64-entry RAM.
// in_tready is low for the whole run; a held output beat does not block
// loads that follow, but a stalled receiver holds the emit scan.
// Configuration (cfg_addr 0 item_count, 1 group_count) must be written only while idle; the block does not enforce it.
// Reset (rst_n low, synchronous) leaves all items ungrouped, no edges,
// item_count 1 and group_count 0; the group and edge stores are cleared after every run.
`default_nettype none
module grouped_topological_sort_core import gts_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   cfg_we,
  input  wire logic                   cfg_addr,
  input  wire logic [NUM_W-1:0]       cfg_wdata,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [15:0]            in_tdata,  // item_index, item_group, before_item
  input  wire logic [1:0]             in_tuser,  // operation
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [7:0]                  out_tdata, // ordered_item, zero fill
  output logic                        out_tuser, // failed
  output logic                        out_tlast
);

  gts_cmd_t         cmd;
  gts_sts_t         sts;
  logic [IDX_W-1:0] out_item;

  gts_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_op     (in_tuser),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  gts_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_op      (in_tuser),
    .in_idx     (in_tdata[4:0]),
    .in_grp     (in_tdata[10:5]),
    .in_bef     (in_tdata[15:11]),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_item   (out_item),
    .out_failed (out_tuser),
    .out_last   (out_tlast)
  );

  assign out_tdata = {(8 - IDX_W)'(0), out_item};

endmodule
`default_nettype wire

// ===== test/grouped_topological_sort_core_tb.sv =====
`default_nettype none
module grouped_topological_sort_core_tb;
  import gts_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic cfg_addr = 1'b0;
  logic [NUM_W-1:0] cfg_wdata = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [15:0] in_tdata = '0;  // item_index, item_group, before_item
  logic [1:0] in_tuser = '0;   // operation
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [7:0] out_tdata;       // ordered_item, zero fill
  logic out_tuser;             // failed
  logic out_tlast;

  grouped_topological_sort_core dut (.*);

  always #2 clk = ~clk;

  typedef struct packed {
    logic [4:0] item;
    logic failed;
    logic last;
  } order_beat_t;

  order_beat_t order_q[$];
  int errors = 0;
  int quiet = 0;
  bit no_idle = 1'b0;

  // predictor copy of the block state
  logic [5:0] m_item_count;
  logic [5:0] m_group_count;
  logic [5:0] m_gof[MAX_ITEMS];
  logic [31:0] m_succ[MAX_ITEMS];

  task automatic clear_model();
    for (int i = 0; i < MAX_ITEMS; i++) begin
      m_gof[i] = NO_GROUP;
      m_succ[i] = '0;
    end
  endtask

  function automatic void queue_beat(order_beat_t b);
    order_q = {order_q, b};
  endfunction

  function automatic int kahn_order(int size, logic [63:0] succ[64], int pend[64],
                                    output int seq[64]);
    int rq[128];
    int head;
    int tail;
    int v;
    head = 0;
    tail = 0;
    for (int k = 0; k < size; k++)
      if (pend[k] == 0) begin
        rq[tail] = k;
        tail++;
      end
    while (head < tail) begin
      v = rq[head];
      seq[head] = v;
      head++;
      for (int k = 0; k < size; k++)
        if (succ[v][k]) begin
          pend[k]--;
          if (pend[k] == 0) begin
            rq[tail] = k;
            tail++;
          end
        end
    end
    return head;
  endfunction

  task automatic predict_sort();
    int n;
    int base;
    int fresh;
    int gid[32];
    logic [63:0] gsucc[64];
    int gpend[64];
    logic [63:0] isucc[64];
    int ipend[64];
    int gseq[64];
    int iseq[64];
    int cnt;
    bit bad;
    order_beat_t b;
    n = m_item_count > 32 ? 32 : m_item_count;
    base = m_group_count > 32 ? 32 : m_group_count;
    fresh = base;
    bad = 1'b0;
    for (int i = 0; i < n; i++)
      if (m_gof[i] < base) gid[i] = m_gof[i];
      else begin
        gid[i] = fresh;
        fresh++;
      end
    if (fresh > MAX_GROUPS) bad = 1'b1;
    for (int g = 0; g < 64; g++) begin
      gsucc[g] = '0;
      gpend[g] = 0;
      isucc[g] = '0;
      ipend[g] = 0;
    end
    if (!bad) begin
      for (int d = 0; d < n; d++)
        for (int i = 0; i < n; i++)
          if (m_succ[d][i]) begin
            isucc[d][i] = 1'b1;
            ipend[i]++;
            if (gid[i] != gid[d] && !gsucc[gid[d]][gid[i]]) begin
              gsucc[gid[d]][gid[i]] = 1'b1;
              gpend[gid[i]]++;
            end
          end
      if (kahn_order(fresh, gsucc, gpend, gseq) != fresh) bad = 1'b1;
      else if (kahn_order(n, isucc, ipend, iseq) != n) bad = 1'b1;
    end
    if (bad) queue_beat(order_beat_t'{item: 5'd0, failed: 1'b1, last: 1'b1});
    else begin
      cnt = 0;
      for (int g = 0; g < fresh; g++)
        for (int i = 0; i < n; i++)
          if (gid[iseq[i]] == gseq[g]) begin
            b = '{item: iseq[i][4:0], failed: 1'b0, last: 1'b0};
            cnt++;
            if (cnt == n) b.last = 1'b1;
            queue_beat(b);
          end
    end
    clear_model();
  endtask

  task automatic idle_gap();
    if (!no_idle && $urandom_range(3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(7, 1)) @(negedge clk);
    end
  endtask

  task automatic send_cmd(gts_op_t op, int idx, int grp, int bef);
    idle_gap();
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {bef[4:0], grp[5:0], idx[4:0]};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    case (op)
      OP_SET_GROUP: m_gof[idx] = grp[5:0];
      OP_ADD_EDGE: m_succ[bef][idx] = 1'b1;
      OP_RUN: predict_sort();
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (order_q.size() != 0 || !in_tready) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic write_cfg(logic addr, int val);
    drain();
    cfg_we <= 1'b1;
    cfg_addr <= addr;
    cfg_wdata <= val[5:0];
    @(negedge clk);
    cfg_we <= 1'b0;
    if (addr == CFG_ITEM_COUNT) m_item_count = val[5:0];
    else m_group_count = val[5:0];
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (order_q.size() == 0) begin
        $display("%0t unexpected beat actual %h/%b/%b", $time, out_tdata, out_tuser,
                 out_tlast);
        errors++;
      end else begin
        if (out_tdata != {3'd0, order_q[0].item} || out_tuser != order_q[0].failed ||
            out_tlast != order_q[0].last) begin
          $display("%0t mismatch expected %h/%b/%b actual %h/%b/%b", $time,
                   order_q[0].item, order_q[0].failed, order_q[0].last,
                   out_tdata, out_tuser, out_tlast);
          errors++;
        end
        void'(order_q.pop_front());
      end
    end
  end

  always @(negedge clk) begin
    if (no_idle) out_tready <= 1'b1;
    else if ($urandom_range(4) == 0) out_tready <= 1'b0;
    else out_tready <= 1'b1;
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet = 0;
    else quiet++;
    if (quiet > 40000) begin
      $display("grouped_topological_sort_core regression: fail");
      $finish;
    end
  end

  task automatic test_directed();
    send_cmd(OP_RUN, 0, 0, 0);
    write_cfg(CFG_ITEM_COUNT, 6);
    write_cfg(CFG_GROUP_COUNT, 2);
    send_cmd(OP_SET_GROUP, 0, 1, 0);
    send_cmd(OP_SET_GROUP, 1, 0, 0);
    send_cmd(OP_SET_GROUP, 2, -1, 0);
    send_cmd(OP_SET_GROUP, 3, 31, 0);
    send_cmd(OP_ADD_EDGE, 0, 0, 1);
    send_cmd(OP_ADD_EDGE, 0, 0, 1);
    send_cmd(OP_ADD_EDGE, 5, 0, 4);
    send_cmd(OP_ADD_EDGE, 31, 0, 2);
    send_cmd(OP_NONE, 31, 31, 31);
    send_cmd(OP_RUN, 0, 0, 0);
    send_cmd(OP_ADD_EDGE, 3, 0, 3);
    send_cmd(OP_RUN, 0, 0, 0);
    send_cmd(OP_ADD_EDGE, 1, 0, 0);
    send_cmd(OP_ADD_EDGE, 0, 0, 1);
    send_cmd(OP_RUN, 0, 0, 0);
    write_cfg(CFG_ITEM_COUNT, 0);
    send_cmd(OP_RUN, 0, 0, 0);
    write_cfg(CFG_ITEM_COUNT, 63);
    write_cfg(CFG_GROUP_COUNT, 63);
    send_cmd(OP_SET_GROUP, 31, 31, 0);
    send_cmd(OP_ADD_EDGE, 0, 0, 31);
    send_cmd(OP_RUN, 0, 0, 0);
  endtask

  task automatic test_random();
    int ic;
    int gc;
    int k;
    int r;
    for (int s = 0; s < 12; s++) begin
      ic = (s % 5 == 0) ? 32 : $urandom_range(12, 1);
      gc = (s % 7 == 0) ? $urandom_range(63, 32) : $urandom_range(ic + 1);
      if (s == 3) gc = 0;
      write_cfg(CFG_ITEM_COUNT, ic);
      write_cfg(CFG_GROUP_COUNT, gc);
      for (int j = 0; j < 3; j++) begin
        k = $urandom_range(5);
        repeat (k) send_cmd(OP_SET_GROUP, $urandom_range(ic - 1), $urandom_range(gc + 1) - 1,
                            0);
        r = $urandom_range(4);
        repeat (k) begin
          if (r == 0) send_cmd(OP_ADD_EDGE, $urandom_range(31), 0, $urandom_range(31));
          else begin
            int a = $urandom_range(ic - 1);
            int c = $urandom_range(ic - 1);
            if (a < c) send_cmd(OP_ADD_EDGE, c, 0, a);
            else if (a > c) send_cmd(OP_ADD_EDGE, a, 0, c);
          end
        end
        if ($urandom_range(9) == 0) send_cmd(OP_NONE, $urandom_range(31), 0, 0);
        send_cmd(OP_RUN, $urandom_range(31), $urandom_range(63) - 32, $urandom_range(31));
      end
    end
  endtask

  task automatic test_no_idle();
    drain();
    no_idle = 1'b1;
    write_cfg(CFG_ITEM_COUNT, 8);
    write_cfg(CFG_GROUP_COUNT, 3);
    for (int j = 0; j < 4; j++) begin
      repeat (4) send_cmd(OP_SET_GROUP, $urandom_range(7), $urandom_range(3) - 1, 0);
      repeat (3) send_cmd(OP_ADD_EDGE, $urandom_range(7), 0, $urandom_range(7));
      send_cmd(OP_RUN, 0, 0, 0);
    end
  endtask

  initial begin
    m_item_count = 6'd1;
    m_group_count = 6'd0;
    clear_model();
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_random();
    test_no_idle();
    drain();
    if (errors == 0 && order_q.size() == 0)
      $display("grouped_topological_sort_core regression: pass");
    else
      $display("grouped_topological_sort_core regression: fail");
    $finish;
  end
endmodule
`default_nettype wire

// ===== filelist.f =====
sv/gts_pkg.sv
sv/gts_ram.sv
sv/gts_ctrl.sv
sv/gts_dp.sv
sv/grouped_topological_sort_core.sv
test/grouped_topological_sort_core_tb.sv
